// ----- design/lru_page_replacement_assert.svh -----
// Assertion macros used by the checker of the LRU replacement block.
// Each expects clk and arst_n in the scope of use.
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

// Same-cycle implication.
`define LRUPR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lru_page_replacement: assertion failed");

// Next-cycle implication.
`define LRUPR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lru_page_replacement: assertion failed");

`endif

// ----- design/lrupr_pkg.sv -----
package lrupr_pkg;

	localparam int PageW       = 16;
	localparam int FrameW      = 3;
	localparam int CountW      = 32;
	localparam int LimitW      = 4;
	localparam int DataW       = 32;
	localparam int PaddrW      = 3;

	localparam int FramesDefault   = 8;
	localparam int PageBitsDefault = 16;

	localparam logic [LimitW-1:0] FrameLimitReset = 4'd4;

	// register index, taken from paddr above the byte offset
	localparam logic [PaddrW-3:0] RegFrameLimit = 1'b0;

	typedef struct packed {
		logic              hit;
		logic [FrameW-1:0] frame;
		logic              evicted_valid;
		logic [PageW-1:0]  evicted_page;
		logic [CountW-1:0] hit_count;
		logic [CountW-1:0] miss_count;
	} rsp_word_t;

endpackage

// ----- design/lrupr_if.sv -----
interface lrupr_in_if;
	import lrupr_pkg::*;

	logic             valid;
	logic             ready;
	logic [PageW-1:0] page;
	logic             last_access;

	modport source (output valid, output page, output last_access, input ready);
	modport sink (input valid, input page, input last_access, output ready);
endinterface

interface lrupr_out_if;
	import lrupr_pkg::*;

	logic              valid;
	logic              ready;
	logic              hit;
	logic [FrameW-1:0] frame;
	logic              evicted_valid;
	logic [PageW-1:0]  evicted_page;
	logic [CountW-1:0] hit_count;
	logic [CountW-1:0] miss_count;

	modport source (output valid, output hit, output frame, output evicted_valid,
		output evicted_page, output hit_count, output miss_count, input ready);
	modport sink (input valid, input hit, input frame, input evicted_valid,
		input evicted_page, input hit_count, input miss_count, output ready);
endinterface

// ----- design/lrupr_frames.sv -----
module lrupr_frames #(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           fire,
	input  logic [PAGE_BITS-1:0]           tag,
	input  logic                           last,
	input  logic [lrupr_pkg::LimitW-1:0]   limit,
	output lrupr_pkg::rsp_word_t           result
);
	import lrupr_pkg::*;

	localparam int IdxW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CntW = $clog2(FRAMES + 1);
	localparam int CmpW = (CntW > LimitW) ? CntW : LimitW;

	logic [PAGE_BITS-1:0] tag_q   [FRAMES];
	logic [IdxW-1:0]      rank_q  [FRAMES];
	logic [IdxW-1:0]      rank_nx [FRAMES];
	logic [FRAMES-1:0]    valid_q;
	logic [CntW-1:0]      occ_q;
	logic [CountW-1:0]    hits_q;
	logic [CountW-1:0]    misses_q;

	logic [FRAMES-1:0]    match;
	logic [FRAMES-1:0]    victim_oh;
	logic [FRAMES-1:0]    sel_oh;
	logic                 hit;
	logic                 fill;
	logic [IdxW-1:0]      hit_idx;
	logic [IdxW-1:0]      free_idx;
	logic [IdxW-1:0]      victim_idx;
	logic [IdxW-1:0]      sel_idx;
	logic [IdxW-1:0]      hit_rank;
	logic [PAGE_BITS-1:0] ev_tag;
	logic [CmpW-1:0]      lim_c;
	logic [CountW-1:0]    hits_nx;
	logic [CountW-1:0]    misses_nx;

	always_comb begin
		hit_idx    = '0;
		free_idx   = '0;
		victim_idx = '0;
		hit_rank   = '0;
		ev_tag     = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			match[i]     = valid_q[i] && (tag_q[i] == tag);
			victim_oh[i] = valid_q[i] && (CntW'(rank_q[i]) == occ_q - CntW'(1));
			if (match[i]) begin
				hit_idx = IdxW'(i);
			end
			if (!valid_q[i]) begin
				free_idx = IdxW'(i);
			end
			if (victim_oh[i]) begin
				victim_idx = IdxW'(i);
			end
		end
		for (int i = 0; i < FRAMES; i++) begin
			if (match[i]) begin
				hit_rank = hit_rank | rank_q[i];
			end
			if (victim_oh[i]) begin
				ev_tag = ev_tag | tag_q[i];
			end
		end
		hit = |match;

		// zero acts as one, anything above the built count as the built count
		lim_c = (limit == '0) ? CmpW'(1) : CmpW'(limit);
		fill  = (CmpW'(occ_q) < lim_c) && (occ_q < CntW'(FRAMES));

		if (hit) begin
			sel_idx = hit_idx;
		end else if (fill) begin
			sel_idx = free_idx;
		end else begin
			sel_idx = victim_idx;
		end

		// age younger frames on a hit, every other valid frame on a miss
		for (int i = 0; i < FRAMES; i++) begin
			sel_oh[i] = (IdxW'(i) == sel_idx);
			if (sel_oh[i]) begin
				rank_nx[i] = '0;
			end else if (valid_q[i] && (!hit || rank_q[i] < hit_rank)) begin
				rank_nx[i] = rank_q[i] + IdxW'(1);
			end else begin
				rank_nx[i] = rank_q[i];
			end
		end

		hits_nx   = hits_q;
		misses_nx = misses_q;
		if (hit && hits_q != '1) begin
			hits_nx = hits_q + CountW'(1);
		end
		if (!hit && misses_q != '1) begin
			misses_nx = misses_q + CountW'(1);
		end

		result.hit           = hit;
		result.frame         = FrameW'(sel_idx);
		result.evicted_valid = !hit && !fill;
		result.evicted_page  = (!hit && !fill) ? PageW'(ev_tag) : '0;
		result.hit_count     = hits_nx;
		result.miss_count    = misses_nx;
	end

	// tags and ranks are only looked at under their valid bit
	always_ff @(posedge clk) begin
		if (fire) begin
			for (int i = 0; i < FRAMES; i++) begin
				rank_q[i] <= rank_nx[i];
				if (sel_oh[i] && !hit) begin
					tag_q[i] <= tag;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			occ_q    <= '0;
			hits_q   <= '0;
			misses_q <= '0;
		end else if (fire) begin
			if (last) begin
				valid_q  <= '0;
				occ_q    <= '0;
				hits_q   <= '0;
				misses_q <= '0;
			end else begin
				valid_q  <= valid_q | sel_oh;
				hits_q   <= hits_nx;
				misses_q <= misses_nx;
				if (!hit && fill) begin
					occ_q <= occ_q + CntW'(1);
				end
			end
		end
	end

endmodule

// ----- design/lru_page_replacement.sv -----
// LRU page replacement unit. Each word on req carries one page reference;
// the unit looks it up in a fully associative set of FRAMES frames and
// answers with one word on rsp: hit or miss, the frame that holds the page
// afterwards, the page evicted (if any) and saturating hit and miss totals
// that include this reference. Misses fill the lowest free frame until
// frame_limit frames are occupied (0 acts as 1, values above FRAMES as
// FRAMES), then replace the least recently used frame. A reference with
// last_access set clears the frames and totals after its answer. The unit
// takes one word per cycle while rsp.ready is high; an input register feeds a
// single pass of parallel tag compare and rank update over all frames, and a
// result register holds the answer. frame_limit sits at byte address 0 of the
// APB port; the user must write it only while idle, unenforced by the unit.
module lru_page_replacement #(
	parameter int FRAMES    = lrupr_pkg::FramesDefault,
	parameter int PAGE_BITS = lrupr_pkg::PageBitsDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	lrupr_in_if.sink                      req,
	lrupr_out_if.source                   rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lrupr_pkg::PaddrW-1:0]  paddr,
	input  logic [lrupr_pkg::DataW-1:0]   pwdata,
	output logic [lrupr_pkg::DataW-1:0]   prdata,
	output logic                          pready
);
	import lrupr_pkg::*;

	// bits of the page that are kept as the tag
	localparam int KeepW = (PAGE_BITS < PageW) ? PAGE_BITS : PageW;

	logic                 valid_s1;
	logic [PAGE_BITS-1:0] tag_s1;
	logic                 last_s1;
	logic                 valid_s2;
	rsp_word_t            word_s2;
	rsp_word_t            result;
	logic                 advance;
	logic [LimitW-1:0]    limit_q;
	logic                 reg_hit;

	// Move the stage-1 word into the result register whenever the result
	// register is empty or being drained this cycle.
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// hold the payload while stage 1 is stalled
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			tag_s1  <= PAGE_BITS'(req.page[KeepW-1:0]);
			last_s1 <= req.last_access;
		end
	end

	lrupr_frames #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_frames (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.tag    (tag_s1),
		.last   (last_s1),
		.limit  (limit_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || rsp.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_s2 <= result;
		end
	end

	assign rsp.valid         = valid_s2;
	assign rsp.hit           = word_s2.hit;
	assign rsp.frame         = word_s2.frame;
	assign rsp.evicted_valid = word_s2.evicted_valid;
	assign rsp.evicted_page  = word_s2.evicted_page;
	assign rsp.hit_count     = word_s2.hit_count;
	assign rsp.miss_count    = word_s2.miss_count;

	// APB register file: only frame_limit, writes land on the access phase
	assign pready  = 1'b1;
	assign reg_hit = (paddr[PaddrW-1:2] == RegFrameLimit);
	assign prdata  = reg_hit ? DataW'(limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= FrameLimitReset;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			limit_q <= pwdata[LimitW-1:0];
		end
	end

endmodule

// ----- design/lrupr_checker.sv -----
`include "lru_page_replacement_assert.svh"

module lrupr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic                            hit,
	input logic [lrupr_pkg::FrameW-1:0]    frame,
	input logic                            evicted_valid,
	input logic [lrupr_pkg::PageW-1:0]     evicted_page,
	input logic [lrupr_pkg::CountW-1:0]    hit_count,
	input logic [lrupr_pkg::CountW-1:0]    miss_count
);

	localparam int RspW = $bits(lrupr_pkg::rsp_word_t);

	logic [RspW-1:0] rsp_bits;

	assign rsp_bits = {hit, frame, evicted_valid, evicted_page, hit_count, miss_count};

	// a stalled result keeps its valid and its word
	`LRUPR_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
	`LRUPR_ASSERT_NXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_bits))

	// only a miss can evict, and a word without an eviction reports page zero
	`LRUPR_ASSERT_IMP(a_evict_on_miss, rsp_valid && evicted_valid, !hit && miss_count != '0)
	`LRUPR_ASSERT_IMP(a_no_evict_page, rsp_valid && !evicted_valid, evicted_page == '0)

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.hit           (rsp.hit),
	.frame         (rsp.frame),
	.evicted_valid (rsp.evicted_valid),
	.evicted_page  (rsp.evicted_page),
	.hit_count     (rsp.hit_count),
	.miss_count    (rsp.miss_count)
);
